/* design/lrt_pkg.sv */
// Shared types, constants and sigmoid table for the logistic regression trainer.
package lrt_pkg;

  localparam int SIGMOID_ENTRIES = 256;
  localparam int SIG_IDX_W       = $clog2(SIGMOID_ENTRIES);

  localparam int FEAT_W   = 16;
  localparam int LR_W     = 16;
  localparam int W_W      = 32;
  localparam int G_W      = 40;
  localparam int PRED_W   = 16;
  localparam int ERR_W    = 18;
  localparam int AERR_W   = 17;
  localparam int SCORE_W  = 38;
  localparam int MUL_A_W  = 40;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int GSUM_W   = G_W + 1;
  localparam int WSUM_W   = W_W + 10;
  localparam int FEAT_FRAC = 12;
  localparam int LR_FRAC   = 16;
  localparam int SIG_OFF_W = 20;

  localparam int ONE_Q16 = 65536;

  localparam logic [LR_W-1:0]   LR_RESET    = LR_W'(655);
  localparam logic [AERR_W-1:0] LEAST_RESET = AERR_W'(ONE_Q16);

  localparam logic signed [SCORE_W-1:0] SIG_HI = SCORE_W'(8 * ONE_Q16);
  localparam logic signed [SCORE_W-1:0] SIG_LO = -SIG_HI;

  localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};
  localparam logic signed [G_W-1:0] G_MAX = {1'b0, {(G_W-1){1'b1}}};
  localparam logic signed [G_W-1:0] G_MIN = {1'b1, {(G_W-1){1'b0}}};

  localparam logic CMD_TRAIN   = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;
  localparam logic KIND_EPOCH  = 1'b0;
  localparam logic KIND_CLASS  = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [FEAT_W-1:0] feat_a;
    logic signed [FEAT_W-1:0] feat_b;
    logic                     label;
    logic                     epoch_end;
  } sample_t;

  typedef struct packed {
    logic                  result_kind;
    logic                  class_out;
    logic signed [W_W-1:0] score_out;
    logic signed [W_W-1:0] bias_out;
    logic signed [W_W-1:0] weight_a_out;
    logic signed [W_W-1:0] weight_b_out;
    logic signed [G_W-1:0] grad_bias_out;
    logic signed [G_W-1:0] grad_a_out;
    logic signed [G_W-1:0] grad_b_out;
    logic [AERR_W-1:0]     min_abs_error;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD_A,
    S_PROD_B,
    S_SCORE,
    S_PREDICT,
    S_GRAD_A,
    S_GRAD_B,
    S_GRAD_SUM,
    S_STEP_0,
    S_STEP_1,
    S_STEP_2,
    S_STEP_SUM,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_WA_XA,
    MUL_WB_XB,
    MUL_ERR_XA,
    MUL_ERR_XB,
    MUL_LR_G0,
    MUL_LR_G1,
    MUL_LR_G2
  } mul_sel_t;

  typedef enum logic [1:0] {
    SC_HOLD,
    SC_LOAD,
    SC_ADD
  } score_op_t;

  typedef enum logic [1:0] {
    GR_HOLD,
    GR_BIAS,
    GR_A,
    GR_B
  } grad_op_t;

  typedef enum logic [1:0] {
    WT_HOLD,
    WT_BIAS,
    WT_A,
    WT_B
  } wt_op_t;

  typedef struct packed {
    mul_sel_t  mul_sel;
    score_op_t score_op;
    grad_op_t  grad_op;
    wt_op_t    wt_op;
    logic      predict;
    logic      emit;
  } ctrl_t;

  typedef logic [SIGMOID_ENTRIES-1:0][PRED_W-1:0] sig_table_t;

  // Unsigned quotient by shift and subtract, used only while building the table.
  function automatic logic [63:0] udiv64(logic [63:0] numer, logic [63:0] denom);
    logic [63:0] quo, rem_v;
    quo   = '0;
    rem_v = '0;
    for (int b = 63; b >= 0; b--) begin
      rem_v = {rem_v[62:0], numer[b]};
      if (rem_v >= denom) begin
        rem_v  = rem_v - denom;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid at bin midpoints: exp(-|m|) from a Taylor series of exp(-|m|/256),
  // raised to the 256th power by eight squarings, all in Q.32.
  function automatic sig_table_t build_table();
    sig_table_t  tbl;
    logic [63:0] one, an, t, v, v2, v3, v4, e, den, numr;
    longint      num;
    logic        pos;
    one = 64'd1 << 32;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      num = -16 * longint'(SIGMOID_ENTRIES) + longint'(2 * i + 1) * 16;
      pos = num > 0;
      an  = pos ? 64'(num) : 64'(-num);
      t   = (an << 32) / 64'(2 * SIGMOID_ENTRIES);
      v   = t >> 8;
      v2  = (v * v) >> 32;
      v3  = (v2 * v) >> 32;
      v4  = (v3 * v) >> 32;
      e   = one - v + v2 / 64'd2 - v3 / 64'd6 + v4 / 64'd24;
      for (int k = 0; k < 8; k++) begin
        e = (e * e) >> 32;
      end
      den    = one + e;
      numr   = pos ? (one << 16) : (e << 16);
      tbl[i] = PRED_W'(udiv64(numr + den / 64'd2, den));
    end
    return tbl;
  endfunction

  localparam sig_table_t SIGMOID_TABLE = build_table();

endpackage

/* design/lrt_mul.sv */
// Shared signed multiplier with registered product.
module lrt_mul
  import lrt_pkg::*;
(
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic signed [PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* design/lrt_seq.sv */
// Sequencer that steps one item through the shared multiplier.
module lrt_seq
  import lrt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  sample_valid,
  output logic  sample_ready,
  input  logic  command,
  input  logic  epoch_end,
  input  logic  result_free,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    sample_ready  = 1'b0;
    ctrl.mul_sel  = MUL_IDLE;
    ctrl.score_op = SC_HOLD;
    ctrl.grad_op  = GR_HOLD;
    ctrl.wt_op    = WT_HOLD;
    ctrl.predict  = 1'b0;
    ctrl.emit     = 1'b0;
    case (state)
      S_IDLE: begin
        sample_ready = !rst;
        if (sample_valid) state_next = S_PROD_A;
      end
      S_PROD_A: begin
        ctrl.mul_sel = MUL_WA_XA;
        state_next   = S_PROD_B;
      end
      S_PROD_B: begin
        ctrl.mul_sel  = MUL_WB_XB;
        ctrl.score_op = SC_LOAD;
        state_next    = S_SCORE;
      end
      S_SCORE: begin
        ctrl.score_op = SC_ADD;
        state_next    = (command == CMD_QUERY) ? S_EMIT : S_PREDICT;
      end
      S_PREDICT: begin
        ctrl.predict = 1'b1;
        state_next   = S_GRAD_A;
      end
      S_GRAD_A: begin
        ctrl.mul_sel = MUL_ERR_XA;
        ctrl.grad_op = GR_BIAS;
        state_next   = S_GRAD_B;
      end
      S_GRAD_B: begin
        ctrl.mul_sel = MUL_ERR_XB;
        ctrl.grad_op = GR_A;
        state_next   = S_GRAD_SUM;
      end
      S_GRAD_SUM: begin
        ctrl.grad_op = GR_B;
        state_next   = epoch_end ? S_STEP_0 : S_IDLE;
      end
      S_STEP_0: begin
        ctrl.mul_sel = MUL_LR_G0;
        state_next   = S_STEP_1;
      end
      S_STEP_1: begin
        ctrl.mul_sel = MUL_LR_G1;
        ctrl.wt_op   = WT_BIAS;
        state_next   = S_STEP_2;
      end
      S_STEP_2: begin
        ctrl.mul_sel = MUL_LR_G2;
        ctrl.wt_op   = WT_A;
        state_next   = S_STEP_SUM;
      end
      S_STEP_SUM: begin
        ctrl.wt_op = WT_B;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        ctrl.emit = result_free;
        if (result_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> state == S_PROD_A)
    else $error("accepted item did not start the score products");

  a_update_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP_SUM |=> state == S_EMIT)
    else $error("weight update not followed by report");

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> state == S_IDLE)
    else $error("sequencer did not return to idle after emit");

endmodule

/* design/logistic_regression_trainer.sv */
// Top level of the two-feature logistic regression trainer.
//
// Trains three weights (bias, weight_a, weight_b, signed Q16.16) by batch
// gradient descent over a stream of samples, and answers classify queries.
// All products go through one shared 40x18 signed multiplier whose product
// is registered, so an item runs as a short sequence with one product per
// cycle and sample_ready is low until it is done. After an accepted item the
// block runs: for a query, two score products, score sum and report; for a
// training sample without epoch_end, two score products, score sum, sigmoid
// lookup, two gradient products and the last gradient sum; for the sample
// ending an epoch, these plus three learn-rate products, the last weight sum
// and the report. A query or epoch report is held in an output register; the
// report cycle waits only while a previous result is still held there. The
// sigmoid comes from a constant table of SIGMOID_ENTRIES entries over [-8,8).
// learn_rate (unsigned Q0.16, reset 655) is written through cfg_we/cfg_wdata;
// the user must write it only while idle; the block does not enforce that.
module logistic_regression_trainer
  import lrt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  output logic            sample_ready,
  input  sample_t         sample,
  output logic            result_valid,
  input  logic            result_ready,
  output result_t         result,
  input  logic            cfg_we,
  input  logic [LR_W-1:0] cfg_wdata
);

  ctrl_t ctrl;
  logic  result_free;

  // Item held for the whole sequence.
  sample_t item;

  // Model state.
  logic [LR_W-1:0]       learn_rate;
  logic signed [W_W-1:0] w [3];
  logic signed [G_W-1:0] g [3];
  logic [AERR_W-1:0]     least_error;

  // Working registers.
  logic signed [SCORE_W-1:0] score;
  logic signed [ERR_W-1:0]   err;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  // Combinational datapath.
  logic signed [SCORE_W-1:0]  score_term;
  logic signed [W_W-1:0]      score_sat;
  logic [SCORE_W-W_W:0]       score_hi;
  logic [SCORE_W-1:0]         sig_off;
  logic [SIG_OFF_W+SIG_IDX_W:0] sig_prod;
  logic [SIG_IDX_W-1:0]       sig_idx;
  logic [PRED_W-1:0]          pred;
  logic signed [ERR_W-1:0]    err_next;
  logic [AERR_W-1:0]          aerr;
  logic [1:0]                 g_idx;
  logic signed [GSUM_W-1:0]   g_addend;
  logic signed [GSUM_W-1:0]   g_sum;
  logic signed [G_W-1:0]      g_sat;
  logic [1:0]                 w_idx;
  logic signed [WSUM_W-1:0]   w_sum;
  logic [WSUM_W-W_W:0]        w_hi;
  logic signed [W_W-1:0]      w_sat;

  assign result_free = !result_valid || result_ready;

  lrt_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .command      (item.command),
    .epoch_end    (item.epoch_end),
    .result_free  (result_free),
    .ctrl         (ctrl)
  );

  // Route the operands of this step to the multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      MUL_WA_XA: begin
        mul_a = MUL_A_W'(w[1]);
        mul_b = MUL_B_W'(item.feat_a);
      end
      MUL_WB_XB: begin
        mul_a = MUL_A_W'(w[2]);
        mul_b = MUL_B_W'(item.feat_b);
      end
      MUL_ERR_XA: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(item.feat_a);
      end
      MUL_ERR_XB: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(item.feat_b);
      end
      MUL_LR_G0: begin
        mul_a = MUL_A_W'(g[0]);
        mul_b = MUL_B_W'(learn_rate);
      end
      MUL_LR_G1: begin
        mul_a = MUL_A_W'(g[1]);
        mul_b = MUL_B_W'(learn_rate);
      end
      MUL_LR_G2: begin
        mul_a = MUL_A_W'(g[2]);
        mul_b = MUL_B_W'(learn_rate);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lrt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Score: product shifted down to Q16.16 (floor), then summed.
  assign score_term = SCORE_W'(prod >>> FEAT_FRAC);

  // Saturate the score to 32 bits for the query answer.
  assign score_hi  = score[SCORE_W-1:W_W-1];
  assign score_sat = (&score_hi || ~|score_hi) ? score[W_W-1:0]
                   : (score[SCORE_W-1] ? W_MIN : W_MAX);

  // Sigmoid lookup: clamp outside [-8,8), else scale the offset into a bin.
  assign sig_off  = score - SIG_LO;
  assign sig_prod = (SIG_OFF_W+SIG_IDX_W+1)'(sig_off[SIG_OFF_W-1:0])
                  * (SIG_OFF_W+SIG_IDX_W+1)'(SIGMOID_ENTRIES);

  always_comb begin
    if (score < SIG_LO) begin
      sig_idx = '0;
    end else if (score >= SIG_HI) begin
      sig_idx = SIG_IDX_W'(SIGMOID_ENTRIES - 1);
    end else begin
      sig_idx = sig_prod[SIG_OFF_W +: SIG_IDX_W];
    end
  end

  assign pred     = SIGMOID_TABLE[sig_idx];
  assign err_next = (item.label ? ERR_W'(ONE_Q16) : ERR_W'(0)) - ERR_W'(pred);
  assign aerr     = err_next[ERR_W-1] ? AERR_W'(-err_next) : AERR_W'(err_next);

  // Gradient accumulate with 40-bit saturation.
  always_comb begin
    g_idx    = 2'd0;
    g_addend = '0;
    case (ctrl.grad_op)
      GR_BIAS: begin
        g_idx    = 2'd0;
        g_addend = GSUM_W'(err);
      end
      GR_A: begin
        g_idx    = 2'd1;
        g_addend = GSUM_W'(prod >>> FEAT_FRAC);
      end
      GR_B: begin
        g_idx    = 2'd2;
        g_addend = GSUM_W'(prod >>> FEAT_FRAC);
      end
      default: begin
        g_idx    = 2'd0;
        g_addend = '0;
      end
    endcase
  end

  assign g_sum = GSUM_W'(g[g_idx]) + g_addend;
  assign g_sat = (g_sum[GSUM_W-1] == g_sum[G_W-1]) ? g_sum[G_W-1:0]
               : (g_sum[GSUM_W-1] ? G_MIN : G_MAX);

  // Weight update: w + (learn_rate * sum) >> 16, saturated to 32 bits.
  always_comb begin
    case (ctrl.wt_op)
      WT_BIAS: w_idx = 2'd0;
      WT_A:    w_idx = 2'd1;
      WT_B:    w_idx = 2'd2;
      default: w_idx = 2'd0;
    endcase
  end

  assign w_sum = WSUM_W'(w[w_idx]) + WSUM_W'(prod >>> LR_FRAC);
  assign w_hi  = w_sum[WSUM_W-1:W_W-1];
  assign w_sat = (&w_hi || ~|w_hi) ? w_sum[W_W-1:0]
               : (w_sum[WSUM_W-1] ? W_MIN : W_MAX);

  // Hold the item and the working values.
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) item <= sample;
    case (ctrl.score_op)
      SC_LOAD: score <= SCORE_W'(w[0]) + score_term;
      SC_ADD:  score <= score + score_term;
      default: score <= score;
    endcase
    if (ctrl.predict) err <= err_next;
  end

  // Model state.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate  <= LR_RESET;
      least_error <= LEAST_RESET;
      for (int k = 0; k < 3; k++) begin
        w[k] <= '0;
        g[k] <= '0;
      end
    end else begin
      if (cfg_we) learn_rate <= cfg_wdata;
      if (ctrl.predict && (aerr < least_error)) least_error <= aerr;
      if (ctrl.grad_op != GR_HOLD) g[g_idx] <= g_sat;
      if (ctrl.wt_op != WT_HOLD) w[w_idx] <= w_sat;
      // Drop the epoch sums once they are reported.
      if (ctrl.emit && (item.command == CMD_TRAIN)) begin
        for (int k = 0; k < 3; k++) begin
          g[k] <= '0;
        end
      end
    end
  end

  // Output register: hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      result.result_kind   <= (item.command == CMD_QUERY) ? KIND_CLASS : KIND_EPOCH;
      result.class_out     <= (item.command == CMD_QUERY) && (score > 0);
      result.score_out     <= (item.command == CMD_QUERY) ? score_sat : W_W'(0);
      result.bias_out      <= w[0];
      result.weight_a_out  <= w[1];
      result.weight_b_out  <= w[2];
      result.grad_bias_out <= g[0];
      result.grad_a_out    <= g[1];
      result.grad_b_out    <= g[2];
      result.min_abs_error <= least_error;
    end
  end

  a_least_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> least_error <= $past(least_error))
    else $error("smallest error grew");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit && (item.command == CMD_TRAIN) |=> g[0] == '0 && g[1] == '0 && g[2] == '0)
    else $error("epoch sums not cleared after report");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctrl.emit))
    else $error("result appeared without a report step");

endmodule
